// ===== design/trmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths and types for the two-ray midpoint triangulation unit.
// No dependencies; every other design file imports this package.
package trmt_pkg;

   localparam int FRAC_BITS = 16;
   // det carries 4*FRAC_BITS fraction bits, threshold is in units of 2^-32
   localparam int DET_SHIFT = 4 * FRAC_BITS - 32;

   localparam int AXES  = 3;
   localparam int ORG_W = 32;
   localparam int DIR_W = 18;
   localparam int SUM_W = ORG_W + 1;          // o2-o1, o1+o2
   localparam int DD_W  = 2 * DIR_W + 1;      // d.d sums
   localparam int CD_W  = SUM_W + DIR_W + 1;  // c.d sums
   localparam int DET_W = 73;                 // Gram determinant, never negative
   localparam int NN_W  = 89;                 // Cramer numerators
   localparam int NUM_W = 110;                // per-axis numerator
   localparam int MAG_W = NUM_W - 1;          // its magnitude
   localparam int DEN_W = DET_W + 1;          // 2*det
   localparam int QUO_W = 32;
   localparam int THR_W = 32;
   localparam logic [THR_W-1:0] THR_RESET = 32'd4295;

   // split points for the wide products
   localparam int DLO = 19;                   // d.d operand low part
   localparam int CLO = 26;                   // c.d operand low part
   localparam int DCH = 24;                   // det chunk
   localparam int NCH = 30;                   // numerator chunk

   localparam int PRE_STAGES = 10;
   localparam int PIPE_DEPTH = PRE_STAGES + QUO_W + 1;

   localparam logic signed [ORG_W-1:0] COORD_MAX = 32'sh7fffffff;
   localparam logic signed [ORG_W-1:0] COORD_MIN = 32'sh80000000;

   typedef logic signed [ORG_W-1:0] coord_type;
   typedef logic signed [DIR_W-1:0] dir_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } div_lane_type;

endpackage

// ===== design/trmt_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: two rays (origins Q16.16, directions Q1.16) with valid/ready.
// Depends on trmt_pkg.
interface trmt_req_if import trmt_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type first_origin_x;
   coord_type first_origin_y;
   coord_type first_origin_z;
   dir_type   first_dir_x;
   dir_type   first_dir_y;
   dir_type   first_dir_z;
   coord_type second_origin_x;
   coord_type second_origin_y;
   coord_type second_origin_z;
   dir_type   second_dir_x;
   dir_type   second_dir_y;
   dir_type   second_dir_z;

   modport source (
      output valid, first_origin_x, first_origin_y, first_origin_z,
      output first_dir_x, first_dir_y, first_dir_z,
      output second_origin_x, second_origin_y, second_origin_z,
      output second_dir_x, second_dir_y, second_dir_z,
      input  ready
   );
   modport sink (
      input  valid, first_origin_x, first_origin_y, first_origin_z,
      input  first_dir_x, first_dir_y, first_dir_z,
      input  second_origin_x, second_origin_y, second_origin_z,
      input  second_dir_x, second_dir_y, second_dir_z,
      output ready
   );
endinterface

// ===== design/trmt_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel: midpoint (Q16.16) plus parallel and saturation flags.
// Depends on trmt_pkg.
interface trmt_rsp_if import trmt_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type mid_x;
   coord_type mid_y;
   coord_type mid_z;
   logic      parallel_flag;
   logic      saturated_flag;

   modport source (
      output valid, mid_x, mid_y, mid_z, parallel_flag, saturated_flag,
      input  ready
   );
   modport sink (
      input  valid, mid_x, mid_y, mid_z, parallel_flag, saturated_flag,
      output ready
   );
endinterface

// ===== design/trmt_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing
// one divisor. Depends on trmt_pkg.
module trmt_div import trmt_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  div_lane_type       lane_in [AXES],
   input  logic [DEN_W-1:0]   den,
   output div_lane_type       lane_out [AXES]
);

   div_lane_type     lane_ff [QUO_W][AXES];
   logic [DEN_W-1:0] den_ff  [QUO_W];

   div_lane_type     lane_src [QUO_W][AXES];
   logic [DEN_W-1:0] den_src  [QUO_W];
   div_lane_type     lane_in_s [QUO_W][AXES];

   always_comb begin
      logic [MAG_W-1:0] dsh;
      den_src[0]  = den;
      lane_src[0] = lane_in;
      for (int k = 1; k < QUO_W; k++) begin
         den_src[k]  = den_ff[k-1];
         lane_src[k] = lane_ff[k-1];
      end
      // stage k decides quotient bit QUO_W-1-k
      for (int k = 0; k < QUO_W; k++) begin
         dsh = MAG_W'(den_src[k]) << (QUO_W - 1 - k);
         for (int a = 0; a < AXES; a++) begin
            lane_in_s[k][a] = lane_src[k][a];
            if (lane_src[k][a].rem >= dsh) begin
               lane_in_s[k][a].rem = lane_src[k][a].rem - dsh;
               lane_in_s[k][a].quo[QUO_W-1-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_s;
         den_ff  <= den_src;
      end
   end

   assign lane_out = lane_ff[QUO_W-1];

endmodule

// ===== design/two_ray_midpoint_triangulation_unit.sv =====
`timescale 1ns / 1ps
// Two-ray midpoint triangulation, top level. Uses trmt_pkg, trmt_req_if,
// trmt_rsp_if and the quotient pipeline trmt_div.
//
// Takes one request per clock while the response side is not stalled and returns
// one response per request, in order. Ten stages form the dot products, the
// Gram determinant, the Cramer numerators and the per-axis numerator; 32 stages
// of restoring division produce one quotient bit each; a last stage applies
// sign, clamp and the parallel bypass. A stall on the response side freezes the
// whole pipeline; ready drops only while the output holds an untaken response.
// Parallel threshold is written through csr_wr_en/csr_wr_data (reset 4295, units
// of 2^-32) and should be changed only while the pipeline is empty.
module two_ray_midpoint_triangulation_unit import trmt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data,
   trmt_req_if.sink           req_bus,
   trmt_rsp_if.source         rsp_bus
);

   localparam int STG_PAR = 6;                          // stage where par is decided
   localparam int PAR_LEN = PIPE_DEPTH - 1 - STG_PAR;
   localparam int CAR_LEN = STG_PAR;

   localparam int PD_LO_W = DD_W + DLO + 1;
   localparam int PD_HI_W = 2 * DD_W - DLO;
   localparam int PN_LO_W = CLO + 1 + DD_W;
   localparam int PN_HI_W = CD_W - CLO + DD_W;
   localparam int DETP_W  = DET_W + 1;
   localparam int NP_W    = NN_W + 1;
   localparam int PS_W    = DET_W - 2 * DCH + 1 + SUM_W;
   localparam int PT_W    = NCH + 1 + DIR_W;

   typedef struct packed {
      logic signed [SUM_W-1:0] s;
      dir_type                 d1;
      dir_type                 d2;
   } axis_carry_type;

   logic [THR_W-1:0]      thr_ff;
   logic [PIPE_DEPTH-1:0] v_ff;
   logic                  adv;

   coord_type o1 [AXES];
   coord_type o2 [AXES];
   dir_type   d1 [AXES];
   dir_type   d2 [AXES];

   assign o1[0] = req_bus.first_origin_x;
   assign o1[1] = req_bus.first_origin_y;
   assign o1[2] = req_bus.first_origin_z;
   assign o2[0] = req_bus.second_origin_x;
   assign o2[1] = req_bus.second_origin_y;
   assign o2[2] = req_bus.second_origin_z;
   assign d1[0] = req_bus.first_dir_x;
   assign d1[1] = req_bus.first_dir_y;
   assign d1[2] = req_bus.first_dir_z;
   assign d2[0] = req_bus.second_dir_x;
   assign d2[1] = req_bus.second_dir_y;
   assign d2[2] = req_bus.second_dir_z;

   assign adv           = !v_ff[PIPE_DEPTH-1] || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         v_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (adv) begin
            v_ff <= {v_ff[PIPE_DEPTH-2:0], req_bus.valid};
         end
      end
   end

   // ---------------- stage 1: differences, sums, parallel midpoint
   logic signed [SUM_W-1:0] c_ff [AXES];
   axis_carry_type          carry_ff [CAR_LEN][AXES];
   logic [ORG_W-1:0]        pmid_ff [PIPE_DEPTH-1][AXES];
   logic [ORG_W-1:0]        pmid_in [AXES];

   always_comb begin
      logic signed [SUM_W:0] sp1;
      for (int a = 0; a < AXES; a++) begin
         sp1 = (SUM_W+1)'(o1[a]) + (SUM_W+1)'(o2[a]) + (SUM_W+1)'(1);
         pmid_in[a] = sp1[SUM_W-1:1];   // floor((o1+o2+1)/2)
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < AXES; a++) begin
            c_ff[a]           <= SUM_W'(o2[a]) - SUM_W'(o1[a]);
            carry_ff[0][a].s  <= SUM_W'(o1[a]) + SUM_W'(o2[a]);
            carry_ff[0][a].d1 <= d1[a];
            carry_ff[0][a].d2 <= d2[a];
            pmid_ff[0][a]     <= pmid_in[a];
         end
         for (int j = 1; j < CAR_LEN; j++) begin
            carry_ff[j] <= carry_ff[j-1];
         end
         for (int j = 1; j < PIPE_DEPTH - 1; j++) begin
            pmid_ff[j] <= pmid_ff[j-1];
         end
      end
   end

   // ---------------- stage 2: per-axis products
   logic signed [2*DIR_W-1:0]     p11_ff [AXES];
   logic signed [2*DIR_W-1:0]     p22_ff [AXES];
   logic signed [2*DIR_W-1:0]     p12_ff [AXES];
   logic signed [SUM_W+DIR_W-1:0] q1_ff  [AXES];
   logic signed [SUM_W+DIR_W-1:0] q2_ff  [AXES];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < AXES; a++) begin
            p11_ff[a] <= carry_ff[0][a].d1 * carry_ff[0][a].d1;
            p22_ff[a] <= carry_ff[0][a].d2 * carry_ff[0][a].d2;
            p12_ff[a] <= carry_ff[0][a].d1 * carry_ff[0][a].d2;
            q1_ff[a]  <= c_ff[a] * carry_ff[0][a].d1;
            q2_ff[a]  <= c_ff[a] * carry_ff[0][a].d2;
         end
      end
   end

   // ---------------- stage 3: dot products
   logic signed [DD_W-1:0] dd11_ff, dd22_ff, dd12_ff;
   logic signed [CD_W-1:0] cd1_ff, cd2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dd11_ff <= DD_W'(p11_ff[0]) + DD_W'(p11_ff[1]) + DD_W'(p11_ff[2]);
         dd22_ff <= DD_W'(p22_ff[0]) + DD_W'(p22_ff[1]) + DD_W'(p22_ff[2]);
         dd12_ff <= DD_W'(p12_ff[0]) + DD_W'(p12_ff[1]) + DD_W'(p12_ff[2]);
         cd1_ff  <= CD_W'(q1_ff[0]) + CD_W'(q1_ff[1]) + CD_W'(q1_ff[2]);
         cd2_ff  <= CD_W'(q2_ff[0]) + CD_W'(q2_ff[1]) + CD_W'(q2_ff[2]);
      end
   end

   // ---------------- stage 4: split products for det, n1, n2
   logic signed [DLO:0]         dd22_lo, dd12_lo;
   logic signed [DD_W-DLO-1:0]  dd22_hi, dd12_hi;
   logic signed [CLO:0]         cd1_lo, cd2_lo;
   logic signed [CD_W-CLO-1:0]  cd1_hi, cd2_hi;

   assign dd22_lo = $signed({1'b0, dd22_ff[DLO-1:0]});
   assign dd12_lo = $signed({1'b0, dd12_ff[DLO-1:0]});
   assign dd22_hi = dd22_ff[DD_W-1:DLO];
   assign dd12_hi = dd12_ff[DD_W-1:DLO];
   assign cd1_lo  = $signed({1'b0, cd1_ff[CLO-1:0]});
   assign cd2_lo  = $signed({1'b0, cd2_ff[CLO-1:0]});
   assign cd1_hi  = cd1_ff[CD_W-1:CLO];
   assign cd2_hi  = cd2_ff[CD_W-1:CLO];

   logic signed [PD_LO_W-1:0] da_lo_ff, db_lo_ff;
   logic signed [PD_HI_W-1:0] da_hi_ff, db_hi_ff;
   logic signed [PN_LO_W-1:0] n1a_lo_ff, n1b_lo_ff, n2a_lo_ff, n2b_lo_ff;
   logic signed [PN_HI_W-1:0] n1a_hi_ff, n1b_hi_ff, n2a_hi_ff, n2b_hi_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         da_lo_ff  <= dd11_ff * dd22_lo;
         da_hi_ff  <= dd11_ff * dd22_hi;
         db_lo_ff  <= dd12_ff * dd12_lo;
         db_hi_ff  <= dd12_ff * dd12_hi;
         n1a_lo_ff <= cd1_lo * dd22_ff;
         n1a_hi_ff <= cd1_hi * dd22_ff;
         n1b_lo_ff <= cd2_lo * dd12_ff;
         n1b_hi_ff <= cd2_hi * dd12_ff;
         n2a_lo_ff <= cd1_lo * dd12_ff;
         n2a_hi_ff <= cd1_hi * dd12_ff;
         n2b_lo_ff <= cd2_lo * dd11_ff;
         n2b_hi_ff <= cd2_hi * dd11_ff;
      end
   end

   // ---------------- stage 5: recombine partial products
   logic signed [DETP_W-1:0] deta_ff, detb_ff;
   logic signed [NP_W-1:0]   n1a_ff, n1b_ff, n2a_ff, n2b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         deta_ff <= (DETP_W'(da_hi_ff) <<< DLO) + DETP_W'(da_lo_ff);
         detb_ff <= (DETP_W'(db_hi_ff) <<< DLO) + DETP_W'(db_lo_ff);
         n1a_ff  <= (NP_W'(n1a_hi_ff) <<< CLO) + NP_W'(n1a_lo_ff);
         n1b_ff  <= (NP_W'(n1b_hi_ff) <<< CLO) + NP_W'(n1b_lo_ff);
         n2a_ff  <= (NP_W'(n2a_hi_ff) <<< CLO) + NP_W'(n2a_lo_ff);
         n2b_ff  <= (NP_W'(n2b_hi_ff) <<< CLO) + NP_W'(n2b_lo_ff);
      end
   end

   // ---------------- stage 6: det = dd11*dd22 - dd12^2, Cramer numerators
   logic signed [DET_W-1:0] det_f_ff;
   logic signed [NN_W-1:0]  n1_ff, n2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         det_f_ff <= DET_W'(deta_ff - detb_ff);
         n1_ff    <= NN_W'(n1a_ff - n1b_ff);
         n2_ff    <= NN_W'(n2a_ff - n2b_ff);
      end
   end

   // ---------------- stage 7: parallel test, numerator partial products
   logic [PAR_LEN-1:0]      par_ff;
   logic                    par_in;
   logic [DET_W-1:0]        det_u;
   logic signed [DET_W-1:0] det_g_ff;
   logic signed [PS_W-1:0]  ps_ff [AXES][3];
   logic signed [PT_W-1:0]  pt1_ff [AXES][3];
   logic signed [PT_W-1:0]  pt2_ff [AXES][3];

   assign det_u  = $unsigned(det_f_ff);
   // zero det is always parallel, even with a zero threshold
   assign par_in = (det_u == '0) || ((det_u >> DET_SHIFT) < DET_W'(thr_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         par_ff   <= {par_ff[PAR_LEN-2:0], par_in};
         det_g_ff <= det_f_ff;
         for (int a = 0; a < AXES; a++) begin
            ps_ff[a][0]  <= $signed({1'b0, det_u[DCH-1:0]}) * carry_ff[CAR_LEN-1][a].s;
            ps_ff[a][1]  <= $signed({1'b0, det_u[2*DCH-1:DCH]}) * carry_ff[CAR_LEN-1][a].s;
            ps_ff[a][2]  <= $signed({1'b0, det_u[DET_W-1:2*DCH]})
                            * carry_ff[CAR_LEN-1][a].s;
            pt1_ff[a][0] <= $signed({1'b0, n1_ff[NCH-1:0]}) * carry_ff[CAR_LEN-1][a].d1;
            pt1_ff[a][1] <= $signed({1'b0, n1_ff[2*NCH-1:NCH]}) * carry_ff[CAR_LEN-1][a].d1;
            pt1_ff[a][2] <= $signed(n1_ff[NN_W-1:2*NCH]) * carry_ff[CAR_LEN-1][a].d1;
            pt2_ff[a][0] <= $signed({1'b0, n2_ff[NCH-1:0]}) * carry_ff[CAR_LEN-1][a].d2;
            pt2_ff[a][1] <= $signed({1'b0, n2_ff[2*NCH-1:NCH]}) * carry_ff[CAR_LEN-1][a].d2;
            pt2_ff[a][2] <= $signed(n2_ff[NN_W-1:2*NCH]) * carry_ff[CAR_LEN-1][a].d2;
         end
      end
   end

   // ---------------- stage 8: recombine numerator terms
   logic signed [NUM_W-1:0] ta_ff [AXES];
   logic signed [NUM_W-1:0] tb_ff [AXES];
   logic signed [NUM_W-1:0] tc_ff [AXES];
   logic signed [DET_W-1:0] det_h_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         det_h_ff <= det_g_ff;
         for (int a = 0; a < AXES; a++) begin
            ta_ff[a] <= NUM_W'(ps_ff[a][0]) + (NUM_W'(ps_ff[a][1]) <<< DCH)
                        + (NUM_W'(ps_ff[a][2]) <<< (2 * DCH));
            tb_ff[a] <= NUM_W'(pt1_ff[a][0]) + (NUM_W'(pt1_ff[a][1]) <<< NCH)
                        + (NUM_W'(pt1_ff[a][2]) <<< (2 * NCH));
            tc_ff[a] <= NUM_W'(pt2_ff[a][0]) + (NUM_W'(pt2_ff[a][1]) <<< NCH)
                        + (NUM_W'(pt2_ff[a][2]) <<< (2 * NCH));
         end
      end
   end

   // ---------------- stage 9: N = (o1+o2)*det + n1*d1 + n2*d2 + det (rounding)
   logic signed [NUM_W-1:0] num_ff [AXES];
   logic signed [DET_W-1:0] det_i_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         det_i_ff <= det_h_ff;
         for (int a = 0; a < AXES; a++) begin
            num_ff[a] <= ta_ff[a] + tb_ff[a] + tc_ff[a] + NUM_W'(det_h_ff);
         end
      end
   end

   // ---------------- stage 10: magnitude and range check against 2*det*2^31
   div_lane_type     lane_ff [AXES];
   div_lane_type     lane_in [AXES];
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] den_in;
   logic [MAG_W-1:0] lim;

   assign den_in = {det_i_ff, 1'b0};
   assign lim    = MAG_W'(den_in) << (QUO_W - 1);

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         lane_in[a].neg = num_ff[a][NUM_W-1];
         lane_in[a].rem = lane_in[a].neg ? MAG_W'(-num_ff[a]) : MAG_W'(num_ff[a]);
         lane_in[a].quo = '0;
         // floor of a negative value may reach exactly -2^31
         lane_in[a].ovf = lane_in[a].neg ? (lane_in[a].rem > lim)
                                         : (lane_in[a].rem >= lim);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
         den_ff  <= den_in;
      end
   end

   div_lane_type lane_out [AXES];

   trmt_div u_div (
      .clock    (clock),
      .en       (adv),
      .lane_in  (lane_ff),
      .den      (den_ff),
      .lane_out (lane_out)
   );

   // ---------------- output stage: sign, clamp, parallel bypass
   coord_type        mid_in [AXES];
   logic [AXES-1:0]  ovf_vec;
   coord_type        mid_ff [AXES];
   logic             par_out_ff;
   logic             sat_ff;

   always_comb begin
      logic signed [QUO_W:0] qe;
      logic signed [QUO_W:0] qs;
      for (int a = 0; a < AXES; a++) begin
         qe = $signed({1'b0, lane_out[a].quo});
         qs = lane_out[a].neg ? (-qe - (QUO_W+1)'(lane_out[a].rem != '0)) : qe;
         ovf_vec[a] = lane_out[a].ovf;
         if (par_ff[PAR_LEN-1]) begin
            mid_in[a] = pmid_ff[PIPE_DEPTH-2][a];
         end else if (lane_out[a].ovf) begin
            mid_in[a] = lane_out[a].neg ? COORD_MIN : COORD_MAX;
         end else begin
            mid_in[a] = qs[QUO_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff     <= mid_in;
         par_out_ff <= par_ff[PAR_LEN-1];
         sat_ff     <= !par_ff[PAR_LEN-1] && (|ovf_vec);
      end
   end

   assign rsp_bus.valid          = v_ff[PIPE_DEPTH-1];
   assign rsp_bus.mid_x          = mid_ff[0];
   assign rsp_bus.mid_y          = mid_ff[1];
   assign rsp_bus.mid_z          = mid_ff[2];
   assign rsp_bus.parallel_flag  = par_out_ff;
   assign rsp_bus.saturated_flag = sat_ff;

   // ---------------- checks
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.parallel_flag && rsp_bus.saturated_flag))
      else $error("parallel and saturated flags both set");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline moved during a stall");

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.saturated_flag) |->
         (rsp_bus.mid_x == COORD_MAX || rsp_bus.mid_x == COORD_MIN ||
          rsp_bus.mid_y == COORD_MAX || rsp_bus.mid_y == COORD_MIN ||
          rsp_bus.mid_z == COORD_MAX || rsp_bus.mid_z == COORD_MIN))
      else $error("saturation flagged without a clipped coordinate");

endmodule

// ===== dv/two_ray_midpoint_triangulation_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for two_ray_midpoint_triangulation_unit: ray pairs in, midpoints out,
// each response compared against an in-bench triangulation predictor. Needs trmt_pkg,
// trmt_req_if, trmt_rsp_if and the design.
module two_ray_midpoint_triangulation_unit_test;
   import trmt_pkg::*;

   typedef logic signed [191:0] wide_type;

   typedef struct {
      coord_type o1 [3];
      dir_type   d1 [3];
      coord_type o2 [3];
      dir_type   d2 [3];
   } ray_pair_type;

   typedef struct {
      coord_type mid [3];
      logic      par;
      logic      sat;
   } midpoint_type;

   typedef struct {
      ray_pair_type pair;
      bit           has_mid;
      midpoint_type mid;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [THR_W-1:0] csr_wr_data = '0;
   logic [THR_W-1:0] threshold = THR_RESET;

   trmt_req_if req_bus ();
   trmt_rsp_if rsp_bus ();

   two_ray_midpoint_triangulation_unit dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   midpoint_type pending_mids [$];
   int errors = 0;
   int n_requests = 0, n_parallel = 0, n_saturated = 0;
   int idle_cycles = 0;
   bit rsp_no_stall = 0;
   int rsp_hold = 0;

   function automatic midpoint_type triangulate(ray_pair_type p, logic [THR_W-1:0] thr);
      midpoint_type m;
      wide_type o1 [3], o2 [3], d1 [3], d2 [3], c [3];
      wide_type dd11, dd22, dd12, cd1, cd2, det, n1, n2, den, num, q, lo, hi;
      dd11 = 0; dd22 = 0; dd12 = 0; cd1 = 0; cd2 = 0;
      for (int a = 0; a < 3; a++) begin
         o1[a] = p.o1[a]; o2[a] = p.o2[a]; d1[a] = p.d1[a]; d2[a] = p.d2[a];
         c[a] = o2[a] - o1[a];
         dd11 += d1[a] * d1[a];
         dd22 += d2[a] * d2[a];
         dd12 += d1[a] * d2[a];
         cd1 += c[a] * d1[a];
         cd2 += c[a] * d2[a];
      end
      det = dd11 * dd22 - dd12 * dd12;
      m.sat = 0;
      m.par = (det == 0) || ((det >>> DET_SHIFT) < wide_type'({1'b0, thr}));
      lo = wide_type'(COORD_MIN);
      hi = wide_type'(COORD_MAX);
      if (m.par) begin
         for (int a = 0; a < 3; a++) m.mid[a] = coord_type'((o1[a] + o2[a] + 1) >>> 1);
         return m;
      end
      n1 = cd1 * dd22 - cd2 * dd12;
      n2 = cd1 * dd12 - cd2 * dd11;
      den = det + det;
      for (int a = 0; a < 3; a++) begin
         num = det * (o1[a] + o2[a]) + n1 * d1[a] + n2 * d2[a] + det;
         q = num / den;
         if (num < 0 && q * den != num) q -= 1;   // floor, not truncation
         if (q > hi) begin
            q = hi; m.sat = 1;
         end else if (q < lo) begin
            q = lo; m.sat = 1;
         end
         m.mid[a] = coord_type'(q);
      end
      return m;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // response side: mostly ready, with stalls of random length
   always @(negedge clock) begin
      if (rsp_no_stall) begin
         rsp_hold = 0;
         rsp_bus.ready <= 1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_bus.ready <= 0;
      end else if ($urandom_range(99) < 70) begin
         rsp_bus.ready <= 1;
      end else begin
         rsp_hold = pick_gap();
         rsp_bus.ready <= 0;
      end
   end

   // scoreboard and watchdog
   always @(posedge clock) begin
      midpoint_type want;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("watchdog expired with %0d responses outstanding", pending_mids.size());
            $display("Mismatches found");
            $finish;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_mids.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = pending_mids.pop_front();
               if (rsp_bus.mid_x !== want.mid[0]) begin
                  $error("mid_x exp %0d got %0d", want.mid[0], rsp_bus.mid_x); errors++;
               end
               if (rsp_bus.mid_y !== want.mid[1]) begin
                  $error("mid_y exp %0d got %0d", want.mid[1], rsp_bus.mid_y); errors++;
               end
               if (rsp_bus.mid_z !== want.mid[2]) begin
                  $error("mid_z exp %0d got %0d", want.mid[2], rsp_bus.mid_z); errors++;
               end
               if (rsp_bus.parallel_flag !== want.par) begin
                  $error("parallel_flag exp %0b got %0b", want.par, rsp_bus.parallel_flag);
                  errors++;
               end
               if (rsp_bus.saturated_flag !== want.sat) begin
                  $error("saturated_flag exp %0b got %0b", want.sat, rsp_bus.saturated_flag);
                  errors++;
               end
            end
         end
      end
   end

   task automatic send_pair(ray_pair_type p, bit has_mid, midpoint_type typed_mid);
      midpoint_type m;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.first_origin_x = p.o1[0]; req_bus.first_origin_y = p.o1[1];
      req_bus.first_origin_z = p.o1[2];
      req_bus.first_dir_x = p.d1[0]; req_bus.first_dir_y = p.d1[1];
      req_bus.first_dir_z = p.d1[2];
      req_bus.second_origin_x = p.o2[0]; req_bus.second_origin_y = p.o2[1];
      req_bus.second_origin_z = p.o2[2];
      req_bus.second_dir_x = p.d2[0]; req_bus.second_dir_y = p.d2[1];
      req_bus.second_dir_z = p.d2[2];
      req_bus.valid = 1;
      m = triangulate(p, threshold);
      if (has_mid && m != typed_mid) begin
         $error("predictor disagrees with table row %0d", n_requests);
         errors++;
      end
      do @(posedge clock); while (!req_bus.ready);
      pending_mids.push_back(has_mid ? typed_mid : m);
      n_requests++;
      if (m.par) n_parallel++;
      if (m.sat) n_saturated++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid = 0;
      while (pending_mids.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] v);
      drain();
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      threshold = v;
   endtask

   function automatic ray_pair_type random_pair();
      ray_pair_type p;
      int kind;
      kind = $urandom_range(9);
      for (int a = 0; a < 3; a++) begin
         p.o1[a] = $urandom;
         p.o2[a] = $urandom;
         p.d1[a] = $urandom;
         p.d2[a] = $urandom;
         if (kind < 4) begin
            // modest scenes: small origins, unit-ish directions
            p.o1[a] = $signed($urandom_range(2 ** 22)) - 2 ** 21;
            p.o2[a] = $signed($urandom_range(2 ** 22)) - 2 ** 21;
            p.d1[a] = $signed($urandom_range(131072)) - 65536;
            p.d2[a] = $signed($urandom_range(131072)) - 65536;
         end else if (kind < 7) begin
            // nearly parallel: second direction a small perturbation of the first
            p.d2[a] = p.d1[a] + dir_type'($signed($urandom_range(64)) - 32);
         end else if (kind == 7) begin
            p.d2[a] = p.d1[a];
         end
      end
      if (kind == 8) for (int a = 0; a < 3; a++) p.d1[a] = 0;
      return p;
   endfunction

   row_type rows [$];

   function automatic row_type make_row(coord_type o1x, coord_type o2x, dir_type d1v,
                                        dir_type d2v, int d1axis, int d2axis);
      row_type r;
      for (int a = 0; a < 3; a++) begin
         r.pair.o1[a] = o1x; r.pair.o2[a] = o2x;
         r.pair.d1[a] = (a == d1axis) ? d1v : dir_type'(0);
         r.pair.d2[a] = (a == d2axis) ? d2v : dir_type'(0);
      end
      r.has_mid = 0;
      return r;
   endfunction

   initial begin
      row_type r;
      midpoint_type none;
      logic [THR_W-1:0] phase_thr [4];
      req_bus.valid = 0;
      req_bus.first_origin_x = 0; req_bus.first_origin_y = 0; req_bus.first_origin_z = 0;
      req_bus.first_dir_x = 0; req_bus.first_dir_y = 0; req_bus.first_dir_z = 0;
      req_bus.second_origin_x = 0; req_bus.second_origin_y = 0; req_bus.second_origin_z = 0;
      req_bus.second_dir_x = 0; req_bus.second_dir_y = 0; req_bus.second_dir_z = 0;
      rsp_bus.ready = 0;
      none = '{mid: '{0, 0, 0}, par: 0, sat: 0};

      // zero directions: midpoint of origins, read off directly
      r = make_row(0, 0, 0, 0, 0, 0);
      r.has_mid = 1; r.mid = '{mid: '{0, 0, 0}, par: 1, sat: 0}; rows.push_back(r);
      r = make_row(COORD_MAX, COORD_MAX, 0, 0, 0, 0);
      r.has_mid = 1; r.mid = '{mid: '{COORD_MAX, COORD_MAX, COORD_MAX}, par: 1, sat: 0};
      rows.push_back(r);
      r = make_row(COORD_MIN, COORD_MIN, 0, 0, 0, 0);
      r.has_mid = 1; r.mid = '{mid: '{COORD_MIN, COORD_MIN, COORD_MIN}, par: 1, sat: 0};
      rows.push_back(r);
      r = make_row(COORD_MAX, COORD_MIN, 0, 0, 0, 0);
      r.has_mid = 1; r.mid = '{mid: '{0, 0, 0}, par: 1, sat: 0}; rows.push_back(r);
      r = make_row(-1, 0, 0, 0, 0, 0);
      r.has_mid = 1; r.mid = '{mid: '{0, 0, 0}, par: 1, sat: 0}; rows.push_back(r);
      r = make_row(-3, 0, 0, 0, 0, 0);
      r.has_mid = 1; r.mid = '{mid: '{-1, -1, -1}, par: 1, sat: 0}; rows.push_back(r);
      // axis-aligned rays: perpendicular pairs with extreme or tiny directions, and one parallel pair
      rows.push_back(make_row(0, 32'sh10000, 18'sh1ffff, 18'sh1ffff, 0, 1));
      rows.push_back(make_row(COORD_MAX, COORD_MIN, -18'sh20000, -18'sh20000, 0, 1));
      rows.push_back(make_row(COORD_MIN, COORD_MAX, 18'sh1ffff, -18'sh20000, 1, 2));
      rows.push_back(make_row(COORD_MAX, COORD_MAX, -18'sh20000, 18'sh1ffff, 2, 0));
      rows.push_back(make_row(32'sh123456, -32'sh654321, 1, 1, 0, 1));
      rows.push_back(make_row(32'sh123456, -32'sh654321, 18'sh10000, 18'sh10000, 0, 0));
      // near parallel: small determinant, huge ray parameters
      r = make_row(32'sh10000, -32'sh10000, 18'sh10000, 18'sh10000, 0, 0);
      r.pair.d2[1] = 1; r.pair.o2[2] = COORD_MAX; rows.push_back(r);
      r = make_row(COORD_MIN, COORD_MAX, -18'sh20000, -18'sh20000, 0, 0);
      r.pair.d2[1] = 18'sh1ffff; rows.push_back(r);

      repeat (5) @(negedge clock);
      reset = 0;

      foreach (rows[i]) send_pair(rows[i].pair, rows[i].has_mid, rows[i].mid);
      // same table with no threshold so near-parallel rows reach the divide and clamp
      write_threshold(0);
      foreach (rows[i]) send_pair(rows[i].pair, 0, none);

      phase_thr[0] = THR_RESET;
      phase_thr[1] = '1;
      phase_thr[2] = $urandom;
      phase_thr[3] = 0;
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(phase_thr[ph]);
         for (int i = 0; i < 270; i++) begin
            rsp_no_stall = (i >= 100 && i < 150);
            send_pair(random_pair(), 0, none);
         end
      end
      rsp_no_stall = 0;
      drain();

      $display("%0d ray pairs checked: %0d parallel, %0d saturated, 6 threshold settings",
               n_requests, n_parallel, n_saturated);
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
